// File: src/varint_zigzag_delta_pair_decoder_macros.svh
// Assertion macros used by the zigzag/delta stage (vzd_entry) of the decoder RTL
`ifndef VARINT_ZIGZAG_DELTA_PAIR_DECODER_MACROS_SVH
`define VARINT_ZIGZAG_DELTA_PAIR_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/vzd_pkg.sv
// Types, constants and helper functions of the varint pair decoder
package vzd_pkg;

  localparam int DATA_W       = 8;
  localparam int DIGIT_W      = 7;
  localparam int VARINT_W     = 64;
  localparam int ADDR_W       = 32;
  localparam int COUNT_W      = 24;
  localparam int ROW_INDEX_W  = 24;
  localparam int POS_W        = 4;
  localparam int MAX_BYTE_POS = 9;
  localparam int ERR_W        = 3;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LONG  = 3'd1,
    ERR_BAD_REF   = 3'd2,
    ERR_BAD_TGT   = 3'd3,
    ERR_EARLY_END = 3'd4
  } vzd_err_t;

  typedef enum logic [2:0] {
    ST_ACTIVE  = 3'b001,
    ST_SUCCESS = 3'b010,
    ST_FAILED  = 3'b100
  } vzd_state_t;

  typedef struct packed {
    logic                more;
    logic                too_long;
    logic [VARINT_W-1:0] raw;
  } vzd_varint_t;

  typedef struct packed {
    logic              entry_valid;
    logic [ADDR_W-1:0] reference_rva;
    logic [ADDR_W-1:0] target_rva;
    logic              target_absent;
    vzd_err_t          error_code;
    logic              done_res;
  } vzd_res_t;

  function automatic logic [VARINT_W-1:0] unzig(input logic [VARINT_W-1:0] v);
    return (v >> 1) ^ {VARINT_W{v[0]}};
  endfunction

  // good address: 1 .. 2^32-1
  function automatic logic addr_ok(input logic [VARINT_W-1:0] a);
    return (a[VARINT_W-1:ADDR_W] == '0) && (a[ADDR_W-1:0] != '0);
  endfunction

endpackage

// File: src/vzd_byte_if.sv
// Payload byte channel
interface vzd_byte_if import vzd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

// File: src/vzd_entry_if.sv
// Decoded entry channel
interface vzd_entry_if import vzd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   entry_valid;
  logic [ROW_INDEX_W-1:0] row_index;
  logic [ADDR_W-1:0]      reference_rva;
  logic [ADDR_W-1:0]      target_rva;
  logic                   target_absent;
  logic [ERR_W-1:0]       error_code;
  logic                   done_res;

  modport source (output valid, entry_valid, row_index, reference_rva, target_rva,
                  target_absent, error_code, done_res, input ready);
  modport sink (input valid, entry_valid, row_index, reference_rva, target_rva,
                target_absent, error_code, done_res, output ready);
endinterface

// File: src/varint_zigzag_delta_pair_decoder.sv
// Top level of the LEB128 zigzag delta address pair decoder
// A byte taken from the byte channel is held in the byte register and decoded into the result
// register. Throughput: one payload byte per cycle while the entry channel is not stalled; the
// varint shift-or, a 64-bit decrement and add and the address range compare sit between them.
// Reset (rst, synchronous): clears entry_count, the varint accumulator, running sums,
// entry counter and finish state; decoding then restarts from the first entry.
module varint_zigzag_delta_pair_decoder import vzd_pkg::*; #(
  parameter int ROW_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  vzd_byte_if.sink           bytes,
  vzd_entry_if.source        entries
);

  logic [COUNT_W-1:0]     entry_count;
  logic                   in_valid;
  logic [DATA_W-1:0]      in_byte;
  logic                   in_last;
  logic                   out_valid;
  vzd_res_t               out_res;
  logic [ROW_INDEX_W-1:0] out_row;

  logic                   process;
  logic                   consume;
  logic                   emit;
  vzd_varint_t            info;
  vzd_res_t               res;
  logic [ROW_INDEX_W-1:0] row_index;

  assign process     = in_valid && (!out_valid || entries.ready);
  assign bytes.ready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.data_byte;
      in_last <= bytes.last_byte;
    end
  end

  vzd_varint u_varint (
    .clk       (clk),
    .rst       (rst),
    .consume   (consume),
    .data_byte (in_byte),
    .info      (info)
  );

  vzd_entry #(
    .ROW_BITS (ROW_BITS)
  ) u_entry (
    .clk         (clk),
    .rst         (rst),
    .process     (process),
    .last_byte   (in_last),
    .entry_count (entry_count),
    .info        (info),
    .consume     (consume),
    .emit        (emit),
    .res         (res),
    .row_index   (row_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (entries.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= res;
      out_row <= row_index;
    end
  end

  assign entries.valid         = out_valid;
  assign entries.entry_valid   = out_res.entry_valid;
  assign entries.row_index     = out_row;
  assign entries.reference_rva = out_res.reference_rva;
  assign entries.target_rva    = out_res.target_rva;
  assign entries.target_absent = out_res.target_absent;
  assign entries.error_code    = out_res.error_code;
  assign entries.done_res      = out_res.done_res;

endmodule

// File: src/vzd_varint.sv
// LEB128 accumulator: shift-or of 7-bit digits and byte position
module vzd_varint import vzd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              consume,
  input  logic [DATA_W-1:0] data_byte,
  output vzd_varint_t       info
);

  logic [VARINT_W-1:0] accum;
  logic [POS_W-1:0]    byte_pos;
  logic [VARINT_W-1:0] shifted;

  always_comb begin
    shifted = '0;
    for (int i = 0; i <= MAX_BYTE_POS; i++) begin
      if (byte_pos == POS_W'(i)) begin
        shifted = VARINT_W'(data_byte[DIGIT_W-1:0]) << (DIGIT_W * i);
      end
    end
  end

  assign info.raw      = accum | shifted;
  assign info.more     = data_byte[DATA_W-1];
  assign info.too_long = data_byte[DATA_W-1] && (byte_pos >= POS_W'(MAX_BYTE_POS));

  always_ff @(posedge clk) begin
    if (rst) begin
      accum    <= '0;
      byte_pos <= '0;
    end else if (consume) begin
      if (info.more) begin
        accum <= info.raw;
        if (!info.too_long) begin
          byte_pos <= byte_pos + 1'b1;
        end
      end else begin
        accum    <= '0;
        byte_pos <= '0;
      end
    end
  end

endmodule

// File: src/vzd_entry.sv
// Zigzag/delta stage: running sums, range checks, entry counter, finish state
`include "varint_zigzag_delta_pair_decoder_macros.svh"

module vzd_entry import vzd_pkg::*; #(
  parameter int ROW_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   process,
  input  logic                   last_byte,
  input  logic [COUNT_W-1:0]     entry_count,
  input  vzd_varint_t            info,
  output logic                   consume,
  output logic                   emit,
  output vzd_res_t               res,
  output logic [ROW_INDEX_W-1:0] row_index
);

  localparam int CmpW = (ROW_BITS > COUNT_W) ? ROW_BITS : COUNT_W;

  vzd_state_t          state, state_next;
  logic                second_half, second_half_next;
  logic [VARINT_W-1:0] reference_sum, reference_sum_next;
  // base_sum tracks reference_sum + slide_sum
  logic [VARINT_W-1:0] base_sum, base_sum_next;
  logic [ROW_BITS-1:0] counter, counter_next;

  logic                active;
  logic                count_reached;
  logic                inc_reached;
  logic [ROW_BITS-1:0] counter_inc;
  logic [VARINT_W-1:0] delta;
  logic [VARINT_W-1:0] ref_new;
  logic [VARINT_W-1:0] base_new;
  logic                raw_zero;

  assign active        = (state == ST_ACTIVE);
  assign count_reached = CmpW'(counter) >= CmpW'(entry_count);
  assign counter_inc   = counter + 1'b1;
  assign inc_reached   = (CmpW'(counter_inc) >= CmpW'(entry_count)) || (counter_inc == '0);
  assign consume       = process && active && !count_reached;
  assign raw_zero      = (info.raw == '0);
  assign delta         = unzig(second_half ? (info.raw - 1'b1) : info.raw);
  assign ref_new       = reference_sum + delta;
  assign base_new      = base_sum + delta;

  always_comb begin
    state_next         = state;
    second_half_next   = second_half;
    reference_sum_next = reference_sum;
    base_sum_next      = base_sum;
    counter_next       = counter;
    emit               = 1'b0;
    res                = '0;
    row_index          = '0;

    if (process && active) begin
      if (count_reached) begin
        emit         = 1'b1;
        res.done_res = 1'b1;
        state_next   = ST_SUCCESS;
      end else if (info.more) begin
        if (info.too_long) begin
          emit           = 1'b1;
          res.error_code = ERR_TOO_LONG;
        end else if (last_byte) begin
          emit           = 1'b1;
          res.error_code = ERR_EARLY_END;
        end
      end else if (!second_half) begin
        reference_sum_next = ref_new;
        base_sum_next      = base_new;
        second_half_next   = 1'b1;
        if (!addr_ok(ref_new)) begin
          emit           = 1'b1;
          res.error_code = ERR_BAD_REF;
        end else if (last_byte) begin
          emit           = 1'b1;
          res.error_code = ERR_EARLY_END;
        end
      end else if (!raw_zero && !addr_ok(base_new)) begin
        emit           = 1'b1;
        res.error_code = ERR_BAD_TGT;
      end else begin
        emit              = 1'b1;
        second_half_next  = 1'b0;
        counter_next      = counter_inc;
        res.entry_valid   = 1'b1;
        res.reference_rva = reference_sum[ADDR_W-1:0];
        res.target_absent = raw_zero;
        if (!raw_zero) begin
          base_sum_next  = base_new;
          res.target_rva = base_new[ADDR_W-1:0];
        end
        if (inc_reached) begin
          res.done_res = 1'b1;
          state_next   = ST_SUCCESS;
        end else if (last_byte) begin
          res.done_res   = 1'b1;
          res.error_code = ERR_EARLY_END;
          state_next     = ST_FAILED;
        end
      end

      // failures that carry no entry
      if (emit && !res.entry_valid && res.error_code != ERR_NONE) begin
        res.done_res = 1'b1;
        row_index    = ROW_INDEX_W'(counter);
        state_next   = ST_FAILED;
      end else if (res.entry_valid) begin
        row_index = ROW_INDEX_W'(counter);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_ACTIVE;
      second_half   <= 1'b0;
      reference_sum <= '0;
      base_sum      <= '0;
      counter       <= '0;
    end else begin
      state         <= state_next;
      second_half   <= second_half_next;
      reference_sum <= reference_sum_next;
      base_sum      <= base_sum_next;
      counter       <= counter_next;
    end
  end

  `ASSERT_IMPLIES(a_quiet_after_finish, clk, rst, state != ST_ACTIVE, !emit && !consume)
  `ASSERT_NEXT(a_done_ends_decoding, clk, rst, emit && res.done_res, state != ST_ACTIVE)
  `ASSERT_IMPLIES(a_entry_ref_nonzero, clk, rst, emit && res.entry_valid, res.reference_rva != '0)
  `ASSERT_IMPLIES(a_entry_tgt_nonzero, clk, rst,
                  emit && res.entry_valid && !res.target_absent, res.target_rva != '0)

endmodule

// File: tb/varint_zigzag_delta_pair_decoder_tb.sv
// Self-checking testbench of the LEB128 zigzag delta address pair decoder
module varint_zigzag_delta_pair_decoder_tb import vzd_pkg::*; ();

  localparam int CYCLE_LIMIT = 300000;
  localparam bit [63:0] ADDR_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic                   entry_valid;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [ADDR_W-1:0]      reference_rva;
    logic [ADDR_W-1:0]      target_rva;
    logic                   target_absent;
    logic [ERR_W-1:0]       error_code;
    logic                   done_res;
  } entry_result_t;

  class entry_scoreboard;
    bit [COUNT_W-1:0]     entry_count;
    bit [VARINT_W-1:0]    accum;
    bit [POS_W-1:0]       pos;
    bit                   in_target;
    bit [VARINT_W-1:0]    ref_sum;
    bit [VARINT_W-1:0]    slide_sum;
    bit [ROW_INDEX_W-1:0] rows_done;
    vzd_state_t           state;
    entry_result_t        expected_entries[$];
    int                   mismatches;

    function void clear_state();
      entry_count = '0;
      accum = '0;
      pos = '0;
      in_target = 1'b0;
      ref_sum = '0;
      slide_sum = '0;
      rows_done = '0;
      state = ST_ACTIVE;
      expected_entries.delete();
    endfunction

    function void set_count(bit [COUNT_W-1:0] v);
      entry_count = v;
    endfunction

    function bit [VARINT_W-1:0] unzigzag(bit [VARINT_W-1:0] v);
      return (v >> 1) ^ (64'd0 - {63'd0, v[0]});
    endfunction

    function bit in_range(bit [VARINT_W-1:0] a);
      return (a - 64'd1) <= 64'hFFFF_FFFE;
    endfunction

    function void queue_result(bit valid, bit [ROW_INDEX_W-1:0] row, bit [ADDR_W-1:0] ref_a,
                               bit [ADDR_W-1:0] tgt, bit absent, vzd_err_t err, bit done);
      entry_result_t r;
      r.entry_valid = valid;
      r.row_index = row;
      r.reference_rva = ref_a;
      r.target_rva = tgt;
      r.target_absent = absent;
      r.error_code = err;
      r.done_res = done;
      expected_entries.insert(expected_entries.size(), r);
    endfunction

    function void abort(vzd_err_t err);
      state = ST_FAILED;
      queue_result(1'b0, rows_done, '0, '0, 1'b0, err, 1'b1);
    endfunction

    function void take_byte(bit [DATA_W-1:0] b, bit last);
      bit [VARINT_W-1:0]    raw;
      bit [VARINT_W-1:0]    tgt;
      bit [ROW_INDEX_W-1:0] row;
      vzd_err_t             err;
      bit                   done;
      if (state != ST_ACTIVE) return;
      if (rows_done >= entry_count) begin
        state = ST_SUCCESS;
        queue_result(1'b0, '0, '0, '0, 1'b0, ERR_NONE, 1'b1);
        return;
      end
      accum |= 64'(b[6:0]) << (7 * pos);
      if (b[7]) begin
        if (pos >= 4'(MAX_BYTE_POS)) begin
          abort(ERR_TOO_LONG);
          return;
        end
        pos++;
        if (last) abort(ERR_EARLY_END);
        return;
      end
      raw = accum;
      accum = '0;
      pos = '0;
      if (!in_target) begin
        ref_sum += unzigzag(raw);
        if (!in_range(ref_sum)) begin
          abort(ERR_BAD_REF);
          return;
        end
        in_target = 1'b1;
        if (last) abort(ERR_EARLY_END);
        return;
      end
      row = rows_done;
      tgt = '0;
      err = ERR_NONE;
      done = 1'b0;
      if (raw != 0) begin
        slide_sum += unzigzag(raw - 64'd1);
        tgt = ref_sum + slide_sum;
        if (!in_range(tgt)) begin
          abort(ERR_BAD_TGT);
          return;
        end
      end
      in_target = 1'b0;
      rows_done++;
      if (rows_done >= entry_count || rows_done == 0) begin
        state = ST_SUCCESS;
        done = 1'b1;
      end else if (last) begin
        state = ST_FAILED;
        err = ERR_EARLY_END;
        done = 1'b1;
      end
      queue_result(1'b1, row, ref_sum[31:0], tgt[31:0], raw == 0, err, done);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_entry(entry_result_t got);
      entry_result_t want;
      if (expected_entries.size() == 0) begin
        report($sformatf("unexpected result, row %0d", got.row_index));
        return;
      end
      want = expected_entries.pop_front();
      compare_field("entry_valid", 32'(got.entry_valid), 32'(want.entry_valid));
      compare_field("row_index", 32'(got.row_index), 32'(want.row_index));
      compare_field("reference_rva", got.reference_rva, want.reference_rva);
      compare_field("target_rva", got.target_rva, want.target_rva);
      compare_field("target_absent", 32'(got.target_absent), 32'(want.target_absent));
      compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
      compare_field("done_res", 32'(got.done_res), 32'(want.done_res));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  vzd_byte_if  bytes_if ();
  vzd_entry_if entries_if ();

  varint_zigzag_delta_pair_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .bytes       (bytes_if),
    .entries     (entries_if)
  );

  entry_scoreboard sb = new();

  bit                idle_on = 1'b1;
  int                bytes_sent;
  int                cycles;
  bit [VARINT_W-1:0] gen_ref;
  bit [VARINT_W-1:0] gen_slide;
  int                gen_rows;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      sb.clear_state();
    end else begin
      entry_result_t got;
      if (cfg_wr_en) sb.set_count(cfg_wr_data);
      if (bytes_if.valid && bytes_if.ready) sb.take_byte(bytes_if.data_byte, bytes_if.last_byte);
      if (entries_if.valid && entries_if.ready) begin
        got.entry_valid = entries_if.entry_valid;
        got.row_index = entries_if.row_index;
        got.reference_rva = entries_if.reference_rva;
        got.target_rva = entries_if.target_rva;
        got.target_absent = entries_if.target_absent;
        got.error_code = entries_if.error_code;
        got.done_res = entries_if.done_res;
        sb.check_entry(got);
      end
    end
  end

  // result side backpressure
  initial begin
    entries_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        entries_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      entries_if.ready <= 1'b1;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input bit [7:0] b, input bit last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      bytes_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.data_byte <= b;
    bytes_if.last_byte <= last;
    do @(posedge clk); while (!bytes_if.ready);
    bytes_sent++;
  endtask

  task automatic drain();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_entries.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_entry_count(input bit [COUNT_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic bit [63:0] zigzag(bit [63:0] d);
    return (d << 1) ^ {64{d[63]}};
  endfunction

  // min_len above the minimal length pads with continuation bytes
  task automatic send_varint(input bit [63:0] v, input int min_len, input bit last);
    int n;
    int len;
    bit [7:0] b;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    len = (min_len > n) ? min_len : n;
    if (len > 10) len = 10;
    for (int i = 0; i < len; i++) begin
      if (i == 9) b = {1'b0, 6'($urandom), v[63]};
      else b = {i < len - 1, 7'(v >> (7 * i))};
      send_byte(b, last && (i == len - 1));
    end
  endtask

  task automatic put_entry(input bit [63:0] new_ref, input bit absent, input bit [63:0] new_tgt,
                           input int ref_pad, input int tgt_pad, input bit last);
    bit [63:0] slide;
    send_varint(zigzag(new_ref - gen_ref), ref_pad, 1'b0);
    gen_ref = new_ref;
    if (absent) begin
      send_varint(64'd0, tgt_pad, last);
    end else begin
      slide = new_tgt - new_ref;
      send_varint(zigzag(slide - gen_slide) + 64'd1, tgt_pad, last);
      gen_slide = slide;
    end
    gen_rows++;
  endtask

  function automatic bit [63:0] pick_addr(bit [63:0] base);
    bit [63:0] a;
    bit [63:0] offset;
    case ($urandom_range(0, 9))
      0: a = 64'd1;
      1: a = ADDR_MAX;
      2, 3: a = {32'd0, 32'($urandom)};
      default: begin
        offset = 64'($urandom_range(0, 1 << $urandom_range(0, 24)));
        a = $urandom_range(0, 1) ? base + offset : base - offset;
      end
    endcase
    if (a == 0 || a > ADDR_MAX) a = {32'd0, 32'($urandom) | 32'd1};
    return a;
  endfunction

  function automatic bit [63:0] pick_bad_addr();
    return $urandom_range(0, 1) ? 64'd0 : 64'h1_0000_0000 + 64'($urandom);
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 1;
  endfunction

  task automatic random_entry(input bit last);
    put_entry(pick_addr(gen_ref), $urandom_range(0, 4) == 0, pick_addr(gen_ref + gen_slide),
              pick_pad(), pick_pad(), last);
  endtask

  task automatic finish_decoding();
    bit [63:0] a;
    case ($urandom_range(0, 7))
      0: begin
        set_entry_count($urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(0, gen_rows)));
        send_byte(8'($urandom), 1'($urandom));
      end
      1: begin
        set_entry_count(24'(gen_rows + 1));
        random_entry(1'($urandom));
      end
      2: send_byte({1'b1, 7'($urandom)}, 1'b1);
      3: begin
        a = pick_addr(gen_ref);
        send_varint(zigzag(a - gen_ref), pick_pad(), 1'b1);
      end
      4: random_entry(1'b1);
      5: begin
        if ($urandom_range(0, 1)) begin
          a = pick_addr(gen_ref);
          send_varint(zigzag(a - gen_ref), 1, 1'b0);
          gen_ref = a;
        end
        repeat (10) send_byte({1'b1, 7'($urandom)}, 1'b0);
      end
      6: put_entry(pick_bad_addr(), 1'b0, 64'd1, pick_pad(), 1, 1'b0);
      default: put_entry(pick_addr(gen_ref), 1'b0, pick_bad_addr(), 1, pick_pad(), 1'b0);
    endcase
    // decoder is finished: everything below must be dropped
    repeat ($urandom_range(4, 12)) send_byte(8'($urandom), 1'($urandom));
    send_byte(8'($urandom), 1'b1);
  endtask

  initial begin
    int phase_start;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    bytes_if.valid <= 1'b0;
    bytes_if.data_byte <= '0;
    bytes_if.last_byte <= 1'b0;
    bytes_sent = 0;
    gen_ref = '0;
    gen_slide = '0;
    gen_rows = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_entry_count(24'hFF_FFFF);
    put_entry(64'd1, 1'b1, 64'd0, 1, 1, 1'b0);
    put_entry(ADDR_MAX, 1'b0, ADDR_MAX, 1, 1, 1'b0);
    put_entry(ADDR_MAX, 1'b0, 64'd1, 10, 1, 1'b0);

    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 2))
        0: set_entry_count(24'hFF_FFFF);
        1: set_entry_count(24'(gen_rows + 200));
        default: set_entry_count(24'($urandom_range(gen_rows + 200, 24'hFF_FFFF)));
      endcase
      if (p == 3) idle_on = 1'b0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 160) random_entry(1'b0);
    end
    finish_decoding();

    drain();
    repeat (8) @(posedge clk);
    if (sb.expected_entries.size() != 0) sb.report("results still outstanding");
    if (sb.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/vzd_pkg.sv
src/vzd_byte_if.sv
src/vzd_entry_if.sv
src/vzd_varint.sv
src/vzd_entry.sv
src/varint_zigzag_delta_pair_decoder.sv
tb/varint_zigzag_delta_pair_decoder_tb.sv
